// ===== rtl/core/lkvc_pkg.sv =====
// Shared constants for the LRU key/value cache: parameter defaults,
// register map and the bit positions of the stream sideband fields.
// No dependencies.
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CAP_W      = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Register index, taken from paddr above the byte offset.
    localparam logic REG_CAPACITY = 1'b0;

    // Result sideband bit positions.
    localparam int USER_HIT   = 0;
    localparam int USER_EVICT = 1;
    localparam int M_USER_W   = 2;

    // Request sideband: operation kind.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/lkvc_cell.sv =====
// One storage cell of the recency chain: a key, a value and a valid bit.
// It matches its key against the request and takes its neighbour's entry on a shift.
// Depends on nothing beyond its parameters.
`default_nettype none

module lkvc_cell #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_shift,
    input  wire logic                  i_prev_valid,
    input  wire logic [KEY_BITS-1:0]   i_prev_key,
    input  wire logic [VALUE_BITS-1:0] i_prev_value,
    input  wire logic [KEY_BITS-1:0]   i_cmp_key,
    output logic                       o_valid,
    output logic [KEY_BITS-1:0]        o_key,
    output logic [VALUE_BITS-1:0]      o_value,
    output logic                       o_match
);

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = r_valid && (r_key == i_cmp_key);

endmodule

`default_nettype wire

// ===== rtl/core/lkvc_cfg_regs.sv =====
// Configuration register file of the LRU key/value cache on an APB-style port.
// Holds the capacity limit. Uses lkvc_pkg for the register map.
`default_nettype none

module lkvc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lkvc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [lkvc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [lkvc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic      [lkvc_pkg::CAP_W-1:0]       o_capacity
);

    logic [lkvc_pkg::CAP_W-1:0] r_capacity;
    logic                       w_sel_cap;

    assign w_sel_cap = (paddr[lkvc_pkg::CFG_ADDR_W-1] == lkvc_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkvc_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && w_sel_cap) begin
            r_capacity <= pwdata[lkvc_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_cap) begin
            prdata[lkvc_pkg::CAP_W-1:0] = r_capacity;
        end
    end

    assign pready     = 1'b1;
    assign o_capacity = r_capacity;

endmodule

`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
// Top level of the LRU key/value cache: a chain of cells kept in recency order,
// the request sequencer and the result register.
// Uses lkvc_pkg, lkvc_cell and lkvc_cfg_regs.
//
//   Port group   Direction  Role
//   s_t*         in         requests: tdata {new_value, lookup_key}, tuser mode
//   m_t*         out        results: tdata {evicted_key, read_value}, tuser {evicted, hit}
//   p*           in/out     configuration registers (capacity limit)
//
// In each transaction the key is matched against every cell at the accepting edge,
// and the chain shifts later in the update state, when the result is registered.
// A new request is taken while a result still waits in the output register.
// If the output register is still full at the update cycle, the update waits there.
// Reset clears every valid bit and the occupancy at once; no clearing pass is needed.
`default_nettype none

module lru_key_value_cache #(
    parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF,
    localparam int DATA_W    = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // lookup_key, new_value, zero padding
    input  wire logic [DATA_W-1:0]                s_tdata,
    // mode
    input  wire logic [0:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // read_value, evicted_key, zero padding
    output logic      [DATA_W-1:0]                m_tdata,
    // hit, evicted
    output logic      [lkvc_pkg::M_USER_W-1:0]    m_tuser,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lkvc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [lkvc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [lkvc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [lkvc_pkg::CAP_W-1:0] w_capacity;

    logic                  r_mode;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [ENTRIES-1:0]    r_match;
    logic [OCC_W-1:0]      r_occ;
    logic [OCC_W-1:0]      n_occ;

    logic                  r_out_valid;
    logic [DATA_W-1:0]     r_out_data;
    logic [lkvc_pkg::M_USER_W-1:0] r_out_user;

    logic [ENTRIES-1:0]    w_valid;
    logic [ENTRIES-1:0]    w_match;
    logic [ENTRIES-1:0]    w_shift;
    logic [ENTRIES-1:0]    w_last;
    logic [KEY_BITS-1:0]   w_key [ENTRIES];
    logic [VALUE_BITS-1:0] w_val [ENTRIES];

    logic                  w_accept;
    logic                  w_go;
    logic                  w_hit;
    logic                  w_full;
    logic                  w_evict;
    logic                  w_apply;
    logic [IDX_W-1:0]      w_hit_pos;
    logic [IDX_W-1:0]      w_pos;
    logic [VALUE_BITS-1:0] w_hit_value;
    logic [KEY_BITS-1:0]   w_last_key;
    logic [VALUE_BITS-1:0] w_new_value;
    logic [VALUE_BITS-1:0] w_read_value;
    logic [KEY_BITS-1:0]   w_evict_key;

    lkvc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (w_capacity)
    );

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            logic                  w_pv;
            logic [KEY_BITS-1:0]   w_pk;
            logic [VALUE_BITS-1:0] w_pd;
            if (gi == 0) begin : g_head
                assign w_pv = 1'b1;
                assign w_pk = r_key;
                assign w_pd = w_new_value;
            end else begin : g_body
                assign w_pv = w_valid[gi-1];
                assign w_pk = w_key[gi-1];
                assign w_pd = w_val[gi-1];
            end
            lkvc_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_shift      (w_shift[gi]),
                .i_prev_valid (w_pv),
                .i_prev_key   (w_pk),
                .i_prev_value (w_pd),
                .i_cmp_key    (s_tdata[KEY_BITS-1:0]),
                .o_valid      (w_valid[gi]),
                .o_key        (w_key[gi]),
                .o_value      (w_val[gi]),
                .o_match      (w_match[gi])
            );
            assign w_shift[gi] = w_apply && (IDX_W'(gi) <= w_pos);
            if (gi == ENTRIES - 1) begin : g_tail
                assign w_last[gi] = w_valid[gi];
            end else begin : g_mid
                assign w_last[gi] = w_valid[gi] && !w_valid[gi+1];
            end
        end
    endgenerate

    assign s_tready = (r_state == ST_IDLE);
    assign w_accept = s_tvalid && s_tready;
    assign w_go     = (r_state == ST_UPDATE) && (!r_out_valid || m_tready);

    always_comb begin
        w_hit_pos   = '0;
        w_hit_value = '0;
        w_last_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_pos   = w_hit_pos | (r_match[i] ? IDX_W'(i) : '0);
            w_hit_value = w_hit_value | (r_match[i] ? w_val[i] : '0);
            w_last_key  = w_last_key | (w_last[i] ? w_key[i] : '0);
        end
    end

    assign w_hit   = |r_match;
    assign w_full  = (CMP_W'(r_occ) >= CMP_W'(w_capacity)) || (r_occ == OCC_W'(ENTRIES));
    assign w_evict = !w_hit && (r_mode == lkvc_pkg::OP_PUT) && w_full;

    always_comb begin
        if (w_hit) begin
            w_pos = w_hit_pos;
        end else if (w_full) begin
            w_pos = IDX_W'(r_occ - OCC_W'(1));
        end else begin
            w_pos = IDX_W'(r_occ);
        end
    end

    assign w_apply = w_go && (w_hit || ((r_mode == lkvc_pkg::OP_PUT)
                                        && !(w_evict && (r_occ == '0))));
    assign w_new_value = (w_hit && (r_mode == lkvc_pkg::OP_GET)) ? w_hit_value : r_value;
    assign w_read_value = (w_hit && (r_mode == lkvc_pkg::OP_GET)) ? w_hit_value : '0;
    assign w_evict_key  = !w_evict ? '0 : ((r_occ == '0) ? r_key : w_last_key);

    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_go) begin
                    n_state = ST_IDLE;
                    if (!w_hit && (r_mode == lkvc_pkg::OP_PUT) && !w_full) begin
                        n_occ = r_occ + OCC_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= s_tuser[0];
            r_key   <= s_tdata[KEY_BITS-1:0];
            r_value <= s_tdata[KEY_BITS +: VALUE_BITS];
            r_match <= w_match;
        end
        if (w_go) begin
            r_out_data <= DATA_W'({w_evict_key, w_read_value});
            r_out_user[lkvc_pkg::USER_HIT]   <= w_hit;
            r_out_user[lkvc_pkg::USER_EVICT] <= w_evict;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_user;

    a_match_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> $onehot0(r_match))
        else $error("more than one cell matched the request key");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid & (w_valid + ENTRIES'(1))) == '0))
        else $error("valid cells do not form a prefix of the chain");

    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (OCC_W'($countones(w_valid)) == r_occ))
        else $error("occupancy disagrees with the valid cells");

    a_accept_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_UPDATE) && !s_tready)
        else $error("accepted transaction did not enter the update cycle");

endmodule

`default_nettype wire
